[rtl/mjm_pkg.sv]
// mjm_pkg: shared types, constants and helpers for the mecanum joystick mixer
// depends on nothing; imported by every module of the block

package mjm_pkg;

  // register indexes of the configuration port
  localparam logic [2:0] REG_STICK_CENTER = 3'd0;
  localparam logic [2:0] REG_DEAD_HALF    = 3'd1;
  localparam logic [2:0] REG_MIN_DRIVE    = 3'd2;
  localparam logic [2:0] REG_RPM_CEILING  = 3'd3;

  // reset values of the registers
  localparam logic [11:0] CENTER_RESET  = 12'd2000;
  localparam logic [10:0] HALF_RESET    = 11'd500;
  localparam logic [6:0]  MIN_RESET     = 7'd40;
  localparam logic [9:0]  CEILING_RESET = 10'd330;

  // default number of fraction bits of the rpm fields
  localparam int RPM_FRAC_DEFAULT = 8;
  localparam int RPM_W            = 18;
  localparam logic [RPM_W-1:0] RPM_MAX = '1;

  // command scaling
  localparam logic [13:0] SUM_LIMIT   = 14'd1500;
  localparam logic [13:0] SMALL_DIV   = 14'd15;
  localparam logic [18:0] PERCENT     = 19'd100;

  // linear rpm law, scaled by 10000
  localparam int          NUM_W       = 25;
  localparam logic [16:0] RPM_SLOPE   = 17'd65267;
  localparam logic [25:0] RPM_OFFSET  = 26'd2439800;
  localparam logic [14:0] RPM_DIVISOR = 15'd10000;

  // 10000 = 16 * 625: shift by four, then reciprocal of 625 scaled by 2**36
  localparam int          PRE_SHIFT   = 4;
  localparam int          RECIP_SHIFT = 36;
  localparam logic [26:0] RECIP_625   = 27'd109951163;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [11:0] stick_center;
    logic [10:0] dead_half_width;
    logic [6:0]  min_drive;
    logic [9:0]  rpm_ceiling;
  } cfg_t;

  typedef struct packed {
    logic signed [7:0] strafe;
    logic signed [7:0] drive;
    logic signed [7:0] turn;
  } cmd_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;
  typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_OUT} back_state_t;

  // quotient by 625 through the reciprocal, exact for any 26 bit dividend
  function automatic logic [16:0] div625(input logic [25:0] z);
    logic [52:0] p;
    p = 53'(z) * 53'(RECIP_625);
    return p[RECIP_SHIFT+16:RECIP_SHIFT];
  endfunction

endpackage

[rtl/mecanum_joystick_mixer.sv]
// mecanum_joystick_mixer: top level, configuration registers and the three parts
// depends on mjm_pkg, mjm_front, mjm_queue, mjm_back
//
//  channel   handshake            payload
//  in        in_valid / in_stall  strafe_stick, drive_stick, turn_stick
//  out       out_valid/ out_stall four *_drive, four *_rpm
//  cfg       cfg_write            cfg_index, cfg_data
//
// front: takes a held request, runs seven divide steps and one hand-off, and
// works on one request at a time; back: mix, multiply, three division steps
// (whole part, remainder, fraction) for the division by 10000, and the output
// load. a new request is held while earlier ones are at work.
// reset is synchronous and restores the register defaults; a stalled result
// holds the back part, and the two-entry queue then stalls the front part.

module mecanum_joystick_mixer #(
  parameter int RPM_FRACTION_BITS = mjm_pkg::RPM_FRAC_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [11:0]               cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [11:0]               strafe_stick,
  input  logic [11:0]               drive_stick,
  input  logic [11:0]               turn_stick,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [7:0]         front_left_drive,
  output logic signed [7:0]         back_left_drive,
  output logic signed [7:0]         front_right_drive,
  output logic signed [7:0]         back_right_drive,
  output logic [mjm_pkg::RPM_W-1:0] front_left_rpm,
  output logic [mjm_pkg::RPM_W-1:0] back_left_rpm,
  output logic [mjm_pkg::RPM_W-1:0] front_right_rpm,
  output logic [mjm_pkg::RPM_W-1:0] back_right_rpm
);
  import mjm_pkg::*;

  cfg_t       cfg;
  logic       push_valid, push_stall, pop_valid, pop_stall;
  cmd_t       push_data, pop_data;
  logic [7:0] drive [4];
  logic [RPM_W-1:0] rpm [4];

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stick_center    <= CENTER_RESET;
      cfg.dead_half_width <= HALF_RESET;
      cfg.min_drive       <= MIN_RESET;
      cfg.rpm_ceiling     <= CEILING_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STICK_CENTER: cfg.stick_center    <= cfg_data;
        REG_DEAD_HALF:    cfg.dead_half_width <= cfg_data[10:0];
        REG_MIN_DRIVE:    cfg.min_drive       <= cfg_data[6:0];
        REG_RPM_CEILING:  cfg.rpm_ceiling     <= cfg_data[9:0];
        default:          ;
      endcase
    end
  end

  mjm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .strafe_stick (strafe_stick),
    .drive_stick  (drive_stick),
    .turn_stick   (turn_stick),
    .push_valid   (push_valid),
    .push_stall   (push_stall),
    .push_data    (push_data)
  );

  mjm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_stall (push_stall),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_stall  (pop_stall),
    .pop_data   (pop_data)
  );

  mjm_back #(
    .RPM_FRACTION_BITS (RPM_FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_stall (pop_stall),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .drive     (drive),
    .rpm       (rpm)
  );

  assign front_left_drive  = drive[0];
  assign back_left_drive   = drive[1];
  assign front_right_drive = drive[2];
  assign back_right_drive  = drive[3];
  assign front_left_rpm    = rpm[0];
  assign back_left_rpm     = rpm[1];
  assign front_right_rpm   = rpm[2];
  assign back_right_rpm    = rpm[3];

endmodule

[rtl/mjm_front.sv]
// mjm_front: input holding stage, deadband and percent command division
// depends on mjm_pkg; feeds mjm_queue

module mjm_front (
  input  logic              clk,
  input  logic              rst,
  input  mjm_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [11:0]       strafe_stick,
  input  logic [11:0]       drive_stick,
  input  logic [11:0]       turn_stick,
  output logic              push_valid,
  input  logic              push_stall,
  output mjm_pkg::cmd_t     push_data
);
  import mjm_pkg::*;

  front_state_t state, state_next;
  logic        hold_valid;
  logic [11:0] hold_mag [3];
  logic        hold_neg [3];
  logic [18:0] rem [3];
  logic [6:0]  quot [3];
  logic        neg [3];
  logic [19:0] den_sh;
  logic [2:0]  cnt;
  logic        take;
  logic        accept;
  logic [11:0] raw [3];
  logic [11:0] db_mag [3];
  logic        db_neg [3];
  logic [13:0] sum;
  logic        big;
  logic [7:0]  cmd [3];

  assign raw[0] = strafe_stick;
  assign raw[1] = drive_stick;
  assign raw[2] = turn_stick;

  // deadband of each raw sample
  always_comb begin
    logic signed [12:0] d;
    logic [11:0]        mag;
    for (int i = 0; i < 3; i++) begin
      d   = $signed({1'b0, raw[i]}) - $signed({1'b0, cfg.stick_center});
      mag = d[12] ? 12'(-d) : d[11:0];
      db_neg[i] = d[12];
      if ({1'b0, mag} < {1'b0, cfg.dead_half_width}) begin
        db_mag[i] = '0;
      end else begin
        db_mag[i] = 12'(mag - 12'(cfg.dead_half_width));
      end
    end
  end

  // input holding register
  assign in_stall = hold_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (take) begin
      hold_valid <= 1'b0;
    end
    if (accept) begin
      for (int i = 0; i < 3; i++) begin
        hold_mag[i] <= db_mag[i];
        hold_neg[i] <= db_neg[i];
      end
    end
  end

  // divisor choice
  assign sum = 14'(hold_mag[0]) + 14'(hold_mag[1]) + 14'(hold_mag[2]);
  assign big = sum >= SUM_LIMIT;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (hold_valid) state_next = F_DIV;
      F_DIV:   if (cnt == 3'd6) state_next = F_PUSH;
      F_PUSH:  if (!push_stall) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    take       = (state == F_IDLE) && hold_valid;
    push_valid = (state == F_PUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // shift and subtract division, seven quotient bits
  always_ff @(posedge clk) begin
    if (take) begin
      cnt    <= '0;
      den_sh <= 20'(big ? sum : SMALL_DIV) << 6;
      for (int i = 0; i < 3; i++) begin
        rem[i]  <= big ? 19'(19'(hold_mag[i]) * PERCENT) : 19'(hold_mag[i]);
        quot[i] <= '0;
        neg[i]  <= hold_neg[i];
      end
    end else if (state == F_DIV) begin
      cnt    <= cnt + 3'd1;
      den_sh <= den_sh >> 1;
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, rem[i]} >= den_sh) begin
          rem[i]  <= 19'({1'b0, rem[i]} - den_sh);
          quot[i] <= {quot[i][5:0], 1'b1};
        end else begin
          quot[i] <= {quot[i][5:0], 1'b0};
        end
      end
    end
  end

  // signed commands
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmd[i] = neg[i] ? 8'(-{1'b0, quot[i]}) : {1'b0, quot[i]};
    end
  end

  assign push_data.strafe = cmd[0];
  assign push_data.drive  = cmd[1];
  assign push_data.turn   = cmd[2];

  // a command never exceeds full scale
  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (quot[0] <= 7'd100 && quot[1] <= 7'd100 && quot[2] <= 7'd100))
    else $error("command magnitude above full scale");

endmodule

[rtl/mjm_queue.sv]
// mjm_queue: short command queue between front and back
// depends on mjm_pkg for the command type and depth

module mjm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_stall,
  input  mjm_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_stall,
  output mjm_pkg::cmd_t pop_data
);
  import mjm_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_stall = (count == CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && !pop_stall;
  assign pop_data   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue overfilled");

endmodule

[rtl/mjm_back.sv]
// mjm_back: wheel mixing, rpm law with reciprocal division by 10000, output register
// depends on mjm_pkg; takes commands from mjm_queue

module mjm_back #(
  parameter int RPM_FRACTION_BITS = mjm_pkg::RPM_FRAC_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mjm_pkg::cfg_t             cfg,
  input  logic                      pop_valid,
  output logic                      pop_stall,
  input  mjm_pkg::cmd_t             pop_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                drive [4],
  output logic [mjm_pkg::RPM_W-1:0] rpm [4]
);
  import mjm_pkg::*;

  localparam int QW        = NUM_W + RPM_FRACTION_BITS;
  localparam int WW        = 14 + RPM_FRACTION_BITS;
  localparam int DIV_STEPS = 3;
  localparam int SW        = $clog2(DIV_STEPS);

  back_state_t      state, state_next;
  logic [SW-1:0]    cnt;
  logic [7:0]       drv [4];
  logic [8:0]       mag [4];
  logic [NUM_W-1:0] num [4];
  logic [11:0]      qa [4];
  logic [13:0]      ra [4];
  logic [QW-1:0]    quo [4];
  logic             pop;
  logic             load_out;
  logic             last;
  logic signed [9:0] wheel [4];

  // mecanum mix
  always_comb begin
    logic signed [9:0] s, f, t;
    s = 10'(pop_data.strafe);
    f = 10'(pop_data.drive);
    t = 10'(pop_data.turn);
    wheel[0] = f + s + t;
    wheel[1] = f - s + t;
    wheel[2] = f - s - t;
    wheel[3] = f + s - t;
  end

  assign last = (cnt == SW'(DIV_STEPS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (pop_valid) state_next = B_MUL;
      B_MUL:   state_next = B_DIV;
      B_DIV:   if (last) state_next = B_OUT;
      B_OUT:   if (!out_valid || !out_stall) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_stall = (state != B_IDLE);
    pop       = (state == B_IDLE) && pop_valid;
    load_out  = (state == B_OUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // per wheel datapath: magnitude, linear law, whole part, remainder, fraction
  always_ff @(posedge clk) begin
    logic [25:0]   prod;
    logic [WW-1:0] scaled;
    if (pop) begin
      for (int i = 0; i < 4; i++) begin
        drv[i] <= wheel[i][7:0];
        mag[i] <= wheel[i][9] ? 9'(-wheel[i]) : wheel[i][8:0];
      end
    end
    if (state == B_MUL) begin
      cnt <= '0;
      for (int i = 0; i < 4; i++) begin
        prod = 26'(mag[i] * RPM_SLOPE);
        if (mag[i] < {2'b0, cfg.min_drive} || prod <= RPM_OFFSET) begin
          num[i] <= '0;
        end else begin
          num[i] <= NUM_W'(prod - RPM_OFFSET);
        end
      end
    end else if (state == B_DIV) begin
      cnt <= cnt + 1'b1;
      for (int i = 0; i < 4; i++) begin
        if (cnt == SW'(0)) begin
          // whole rpm: numerator over 10000
          qa[i] <= 12'(div625(26'(num[i] >> PRE_SHIFT)));
        end else if (cnt == SW'(1)) begin
          // remainder of the whole part
          ra[i] <= 14'(num[i] - NUM_W'(qa[i]) * NUM_W'(RPM_DIVISOR));
        end else begin
          // fraction bits from the remainder
          scaled = WW'(ra[i]) << RPM_FRACTION_BITS;
          quo[i] <= (QW'(qa[i]) << RPM_FRACTION_BITS)
                    + QW'(div625(26'(scaled >> PRE_SHIFT)));
        end
      end
    end
  end

  // output register with ceiling clamp and field saturation
  always_ff @(posedge clk) begin
    logic [QW-1:0] cap, qc;
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      cap = QW'(cfg.rpm_ceiling) << RPM_FRACTION_BITS;
      for (int i = 0; i < 4; i++) begin
        qc       = (quo[i] > cap) ? cap : quo[i];
        drive[i] <= drv[i];
        rpm[i]   <= (qc > QW'(RPM_MAX)) ? RPM_MAX : qc[RPM_W-1:0];
      end
    end
  end

  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    (state == B_OUT && out_valid && out_stall) |=> state == B_OUT)
    else $error("result overwritten while stalled");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == B_MUL)
    else $error("command taken outside idle");

  a_step_count: assert property (@(posedge clk) disable iff (rst)
    state == B_DIV |-> cnt <= SW'(DIV_STEPS - 1))
    else $error("division step count overrun");

endmodule
